// File: design/der_tlv_stream_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// DER TLV stream decoder assertion macros
// Short forms for the concurrent checks used in the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef DER_TLV_STREAM_DECODER_CORE_ASSERT_SVH
`define DER_TLV_STREAM_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DERTLV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DERTLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/dertlv_pkg.sv
// ----------------------------------------------------------------------------
// DER TLV stream decoder package
// Types and fixed codes shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dertlv_pkg;

   typedef logic [1:0] phase_type;
   typedef logic [1:0] kind_type;

   localparam phase_type PH_TAG     = 2'd0;
   localparam phase_type PH_LEN     = 2'd1;
   localparam phase_type PH_LBYTES  = 2'd2;
   localparam phase_type PH_CONTENT = 2'd3;

   localparam kind_type KIND_CONTENT = 2'd0;
   localparam kind_type KIND_EMPTY   = 2'd1;
   localparam kind_type KIND_BAD_TAG = 2'd2;
   localparam kind_type KIND_BAD_LEN = 2'd3;

   localparam logic [7:0] LONG_FORM_MASK = 8'h80;
   localparam logic [7:0] LEN_COUNT_MASK = 8'h7f;
   localparam logic [7:0] LEN_COUNT_MAX  = 8'd4;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   result_kind;
      logic       last;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: design/dertlv_rsp_fifo.sv
// ----------------------------------------------------------------------------
// DER TLV result buffer
// Two-entry result queue that decouples the decoder from a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module dertlv_rsp_fifo
   import dertlv_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_item_type push_item,
   output logic              full,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_item
);

   rsp_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: design/der_tlv_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// DER TLV stream decoder core
// Checks the tag and decodes the length of DER elements, passes content on.
// ----------------------------------------------------------------------------
// The req channel carries one byte of the DER stream per word, together with
// the tag that the current element must carry; the tag is only compared on a
// tag byte. The rsp channel returns at most one word per input byte: a
// content byte (marked last on the final one), an empty-element marker, or
// an error for a wrong tag or a long-form length count of zero or above four.
// Tag and length bytes give no word unless they end the element or fail.
// After an element ends or an error is reported, the next byte is a tag.
// A result word is registered in the result queue before it appears on rsp.
// One byte is accepted per cycle while req_ready is high; the state update is
// a single pass from the accepted byte to a two-entry result queue.
// When the receiver stalls, the queue keeps taking bytes until both entries
// hold results; req_ready then stays low until a word leaves.
// Reset is synchronous and active high: the decoder waits for a tag byte and
// the result queue is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "der_tlv_stream_decoder_core_assert.svh"

module der_tlv_stream_decoder_core
   import dertlv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_expected_tag,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_result_kind,
   output logic            rsp_last
);

   phase_type    phase_ff, phase_in;
   logic [2:0]   lbytes_left_ff, lbytes_left_in;
   logic [31:0]  content_left_ff, content_left_in;
   logic         req_accept;
   logic         res_valid;
   rsp_item_type res_item;
   rsp_item_type out_item;
   logic         fifo_full;
   logic [7:0]   len_count;
   logic [31:0]  len_acc;
   logic [2:0]   lbytes_dec;

   assign req_ready  = !fifo_full;
   assign req_accept = req_valid && req_ready;
   assign len_count  = req_data_byte & LEN_COUNT_MASK;
   assign len_acc    = {content_left_ff[23:0], req_data_byte};
   assign lbytes_dec = (lbytes_left_ff != 3'd0) ? lbytes_left_ff - 3'd1 : 3'd0;

   always_comb begin
      phase_in        = phase_ff;
      lbytes_left_in  = lbytes_left_ff;
      content_left_in = content_left_ff;
      res_valid       = 1'b0;
      res_item        = '0;
      unique case (phase_ff)
         PH_TAG: begin
            if (req_data_byte != req_expected_tag) begin
               res_valid            = 1'b1;
               res_item.result_kind = KIND_BAD_TAG;
               lbytes_left_in       = 3'd0;
               content_left_in      = 32'd0;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if ((req_data_byte & LONG_FORM_MASK) == 8'd0) begin
               if (req_data_byte == 8'd0) begin
                  res_valid            = 1'b1;
                  res_item.result_kind = KIND_EMPTY;
                  res_item.last        = 1'b1;
                  phase_in             = PH_TAG;
                  lbytes_left_in       = 3'd0;
                  content_left_in      = 32'd0;
               end else begin
                  content_left_in = {24'd0, req_data_byte};
                  phase_in        = PH_CONTENT;
               end
            end else if (len_count == 8'd0 || len_count > LEN_COUNT_MAX) begin
               res_valid            = 1'b1;
               res_item.result_kind = KIND_BAD_LEN;
               phase_in             = PH_TAG;
               lbytes_left_in       = 3'd0;
               content_left_in      = 32'd0;
            end else begin
               lbytes_left_in  = len_count[2:0];
               content_left_in = 32'd0;
               phase_in        = PH_LBYTES;
            end
         end
         PH_LBYTES: begin
            content_left_in = len_acc;
            lbytes_left_in  = lbytes_dec;
            if (lbytes_dec == 3'd0) begin
               if (len_acc == 32'd0) begin
                  res_valid            = 1'b1;
                  res_item.result_kind = KIND_EMPTY;
                  res_item.last        = 1'b1;
                  phase_in             = PH_TAG;
                  lbytes_left_in       = 3'd0;
                  content_left_in      = 32'd0;
               end else begin
                  phase_in = PH_CONTENT;
               end
            end
         end
         PH_CONTENT: begin
            res_valid            = 1'b1;
            res_item.out_byte    = req_data_byte;
            res_item.result_kind = KIND_CONTENT;
            if (content_left_ff <= 32'd1) begin
               res_item.last   = 1'b1;
               phase_in        = PH_TAG;
               lbytes_left_in  = 3'd0;
               content_left_in = 32'd0;
            end else begin
               content_left_in = content_left_ff - 32'd1;
            end
         end
         default: begin
            phase_in = PH_TAG;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TAG;
         lbytes_left_ff  <= 3'd0;
         content_left_ff <= 32'd0;
      end else if (req_accept) begin
         phase_ff        <= phase_in;
         lbytes_left_ff  <= lbytes_left_in;
         content_left_ff <= content_left_in;
      end
   end

   dertlv_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && res_valid),
      .push_item (res_item),
      .full      (fifo_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item)
   );

   assign rsp_out_byte    = out_item.out_byte;
   assign rsp_result_kind = out_item.result_kind;
   assign rsp_last        = out_item.last;

   `DERTLV_ASSERT_SAME(a_lbytes_nonzero, clock, reset, phase_ff == PH_LBYTES, lbytes_left_ff != 3'd0, "Length byte count is zero while collecting length bytes.")
   `DERTLV_ASSERT_SAME(a_content_nonzero, clock, reset, phase_ff == PH_CONTENT, content_left_ff != 32'd0, "Content count is zero while passing content.")
   `DERTLV_ASSERT_NEXT(a_tag_to_len, clock, reset, req_accept && phase_ff == PH_TAG && req_data_byte == req_expected_tag, phase_ff == PH_LEN, "Matching tag did not advance to the length byte.")
   `DERTLV_ASSERT_NEXT(a_content_emits, clock, reset, req_accept && phase_ff == PH_CONTENT, rsp_valid, "Content byte produced no result word.")

endmodule

`default_nettype wire
